@@ src/tpsc_pkg.sv @@
// Shared types and constants for the two-wheel PI speed controller.
// No dependencies; used by tpsc_ctrl, tpsc_dp and the top level (not by tpsc_div).
package tpsc_pkg;

  // Fixed-point constants (Q16.16 unless noted)
  localparam logic [12:0]        STEP_Q   = 13'd5147;     // 0.07853981
  localparam logic [16:0]        KEEP_Q   = 17'd39322;    // 0.6
  localparam logic signed [41:0] I_LIMIT  = 42'sd6553600; // 100.0
  localparam logic signed [31:0] DZ_SPEED = 32'sd6554;    // 0.1
  localparam logic signed [31:0] DZ_INT   = 32'sd655360;  // 10.0

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 24;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_KP_RIGHT = 3'd0,
    REG_KP_LEFT  = 3'd1,
    REG_KI_RIGHT = 3'd2,
    REG_KI_LEFT  = 3'd3,
    REG_PERIOD   = 3'd4,
    REG_ENABLE   = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_EDGE,
    OP_SPEED_MUL,
    OP_DIV_START,
    OP_SPEED_FIN,
    OP_FILT_MUL,
    OP_FILT_ADD,
    OP_ERR,
    OP_I_MUL,
    OP_I_ADD,
    OP_P_MUL,
    OP_DRIVE,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic wheel;  // 0 left, 1 right
    logic load;   // input transfer this cycle
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

@@ src/tpsc_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by tpsc_dp.
module tpsc_div #(
  parameter int N = 28
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [15:0]  divisor,
  output logic         done,
  output logic [N-1:0] quotient
);

  localparam int CW = $clog2(N + 1);

  logic [15:0]   rem;
  logic [15:0]   dvs;
  logic [N-1:0]  quo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [16:0]   trial;
  logic          qbit;

  assign trial = {rem, quo[N-1]};
  assign qbit  = (trial >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(N);
        rem  <= '0;
        quo  <= dividend;
        dvs  <= (divisor == 16'd0) ? 16'd1 : divisor;
      end else if (busy) begin
        rem <= qbit ? 16'(trial - {1'b0, dvs}) : trial[15:0];
        quo <= {quo[N-2:0], qbit};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/tpsc_ctrl.sv @@
// Sequencer for edge updates and per-wheel control ticks.
// Depends on tpsc_pkg; drives tpsc_dp through cmd_t.
module tpsc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            in_mode,
  input  tpsc_pkg::stat_t stat,
  output logic            s_tready,
  output tpsc_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_EDGE, ST_SPD_MUL, ST_DIV_START, ST_DIV_WAIT, ST_SPD_FIN,
    ST_FILT_MUL, ST_FILT_ADD, ST_ERR, ST_I_MUL, ST_I_ADD, ST_P_MUL,
    ST_DRIVE, ST_EMIT
  } state_t;

  state_t state;
  logic   wheel;

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wheel <= 1'b1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= in_mode ? ST_SPD_MUL : ST_EDGE;
            wheel <= 1'b1;
          end
        end
        ST_EDGE:      state <= ST_IDLE;
        ST_SPD_MUL:   state <= ST_DIV_START;
        ST_DIV_START: state <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (stat.div_done) state <= ST_SPD_FIN;
        end
        ST_SPD_FIN:   state <= ST_FILT_MUL;
        ST_FILT_MUL:  state <= ST_FILT_ADD;
        ST_FILT_ADD:  state <= ST_ERR;
        ST_ERR:       state <= ST_I_MUL;
        ST_I_MUL:     state <= ST_I_ADD;
        ST_I_ADD:     state <= ST_P_MUL;
        ST_P_MUL:     state <= ST_DRIVE;
        ST_DRIVE: begin
          if (wheel) begin
            wheel <= 1'b0;
            state <= ST_SPD_MUL;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (stat.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.wheel = wheel;
    cmd.load  = (state == ST_IDLE) && s_tvalid;
    unique case (state)
      ST_EDGE:      cmd.op = tpsc_pkg::OP_EDGE;
      ST_SPD_MUL:   cmd.op = tpsc_pkg::OP_SPEED_MUL;
      ST_DIV_START: cmd.op = tpsc_pkg::OP_DIV_START;
      ST_SPD_FIN:   cmd.op = tpsc_pkg::OP_SPEED_FIN;
      ST_FILT_MUL:  cmd.op = tpsc_pkg::OP_FILT_MUL;
      ST_FILT_ADD:  cmd.op = tpsc_pkg::OP_FILT_ADD;
      ST_ERR:       cmd.op = tpsc_pkg::OP_ERR;
      ST_I_MUL:     cmd.op = tpsc_pkg::OP_I_MUL;
      ST_I_ADD:     cmd.op = tpsc_pkg::OP_I_ADD;
      ST_P_MUL:     cmd.op = tpsc_pkg::OP_P_MUL;
      ST_DRIVE:     cmd.op = tpsc_pkg::OP_DRIVE;
      ST_EMIT:      cmd.op = stat.out_free ? tpsc_pkg::OP_EMIT : tpsc_pkg::OP_NONE;
      default:      cmd.op = tpsc_pkg::OP_NONE;
    endcase
  end

endmodule

@@ src/tpsc_dp.sv @@
// Datapath: config registers, wheel state, shared multiply steps, output register.
// Depends on tpsc_pkg and tpsc_div; sequenced by tpsc_ctrl.
module tpsc_dp #(
  parameter int EDGE_COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tpsc_pkg::cmd_t                       cmd,
  output tpsc_pkg::stat_t                      stat,
  input  logic [1:0]                           s_tuser,
  input  logic [71:0]                          s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [31:0]                          m_tdata,
  input  logic                                 cfg_we,
  input  logic [tpsc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [tpsc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int E = EDGE_COUNT_BITS;
  localparam int N = EDGE_COUNT_BITS + 12;  // |count| * STEP_Q fits here

  localparam logic signed [E-1:0]  CNT_MAX = {1'b0, {(E-1){1'b1}}};
  localparam logic signed [E-1:0]  CNT_MIN = {1'b1, {(E-1){1'b0}}};
  localparam logic signed [63:0]   S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0]   S32_MIN = -64'sd2147483648;
  localparam logic [12:0]          STEP_Q_EXT = tpsc_pkg::STEP_Q;

  // config
  logic [23:0] kp_right, kp_left, ki_right, ki_left;
  logic [15:0] period_ms;
  logic        control_enable;

  // latched input
  logic               in_wheel, in_a, in_b;
  logic signed [31:0] tgt [2];

  // wheel state
  logic signed [E-1:0] edge_count [2];
  logic signed [31:0]  filtered_speed [2];
  logic signed [31:0]  integral_sum [2];
  logic signed [31:0]  previous_target [2];

  // working registers
  logic [N-1:0]        mag;
  logic                neg;
  logic signed [31:0]  speed;
  logic signed [48:0]  fprod;
  logic signed [31:0]  err;
  logic signed [56:0]  iprod;
  logic signed [56:0]  pprod;
  logic signed [15:0]  drive_right, drive_left;

  logic                w;
  logic signed [E-1:0] cnt;
  logic [E-1:0]        cnt_abs;
  logic [E+12:0]       mprod;
  logic                div_done;
  logic [N-1:0]        quo;
  logic signed [N:0]   sq;
  logic signed [63:0]  sq64, sat_spd, neg_spd;
  logic signed [32:0]  f_trunc;
  logic signed [36:0]  f_sum;
  logic signed [32:0]  e_diff;
  logic signed [40:0]  i_trunc;
  logic signed [41:0]  i_sum, i_new;
  logic                dz;
  logic signed [57:0]  d_sum, d_adj;
  logic signed [25:0]  d_q;
  logic signed [15:0]  d_sat;
  logic [23:0]         kp_sel, ki_sel;

  assign w       = cmd.wheel;
  assign kp_sel  = w ? kp_right : kp_left;
  assign ki_sel  = w ? ki_right : ki_left;
  assign cnt     = edge_count[w];
  assign cnt_abs = cnt[E-1] ? E'(-cnt) : cnt;
  assign mprod   = cnt_abs * STEP_Q_EXT;

  tpsc_div #(.N(N)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == tpsc_pkg::OP_DIV_START),
    .dividend (mag),
    .divisor  (period_ms),
    .done     (div_done),
    .quotient (quo)
  );

  assign stat.div_done = div_done;
  assign stat.out_free = !m_tvalid || m_tready;

  // speed: apply sign, saturate, negate for the right wheel
  always_comb begin
    sq   = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    sq64 = 64'(sq);
    if (sq64 > S32_MAX)      sat_spd = S32_MAX;
    else if (sq64 < S32_MIN) sat_spd = S32_MIN;
    else                     sat_spd = sq64;
    neg_spd = (sat_spd == S32_MIN) ? S32_MAX : -sat_spd;
  end

  // filter, error, integrator, drive
  always_comb begin
    f_trunc = 33'((fprod + (fprod < 0 ? 49'sd65535 : 49'sd0)) >>> 16);
    f_sum   = 37'(f_trunc) + 37'(speed) * 37'sd10;
    e_diff  = 33'(tgt[w]) - 33'(filtered_speed[w]);
    i_trunc = 41'((iprod + (iprod < 0 ? 57'sd65535 : 57'sd0)) >>> 16);
    i_sum   = 42'(i_trunc) + 42'(integral_sum[w]);
    if (i_sum > tpsc_pkg::I_LIMIT)       i_new = tpsc_pkg::I_LIMIT;
    else if (i_sum < -tpsc_pkg::I_LIMIT) i_new = -tpsc_pkg::I_LIMIT;
    else                                 i_new = i_sum;
    dz = (speed < tpsc_pkg::DZ_SPEED) && (speed > -tpsc_pkg::DZ_SPEED) &&
         (integral_sum[w] < tpsc_pkg::DZ_INT) && (integral_sum[w] > -tpsc_pkg::DZ_INT);
    d_sum = dz ? 58'(pprod) : 58'(pprod) + (58'(integral_sum[w]) <<< 16);
    d_adj = d_sum + (d_sum < 0 ? 58'sd4294967295 : 58'sd0);
    d_q   = d_adj[57:32];
    if (d_q > 26'sd32767)       d_sat = 16'sh7fff;
    else if (d_q < -26'sd32768) d_sat = 16'sh8000;
    else                        d_sat = d_q[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_right       <= 24'd4921098;
      kp_left        <= 24'd11141120;
      ki_right       <= 24'd3932;
      ki_left        <= 24'd3932;
      period_ms      <= 16'd100;
      control_enable <= 1'b1;
      m_tvalid       <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        edge_count[i]      <= '0;
        filtered_speed[i]  <= '0;
        integral_sum[i]    <= '0;
        previous_target[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tpsc_pkg::REG_KP_RIGHT: kp_right       <= cfg_data;
          tpsc_pkg::REG_KP_LEFT:  kp_left        <= cfg_data;
          tpsc_pkg::REG_KI_RIGHT: ki_right       <= cfg_data;
          tpsc_pkg::REG_KI_LEFT:  ki_left        <= cfg_data;
          tpsc_pkg::REG_PERIOD:   period_ms      <= cfg_data[15:0];
          tpsc_pkg::REG_ENABLE:   control_enable <= cfg_data[0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      if (cmd.load) begin
        in_wheel <= s_tuser[1];
        in_a     <= s_tdata[0];
        in_b     <= s_tdata[1];
        tgt[1]   <= s_tdata[33:2];
        tgt[0]   <= s_tdata[65:34];
      end

      case (cmd.op)
        tpsc_pkg::OP_EDGE: begin
          if (in_a == in_b) begin
            if (edge_count[in_wheel] != CNT_MAX)
              edge_count[in_wheel] <= edge_count[in_wheel] + E'(1);
          end else if (edge_count[in_wheel] != CNT_MIN) begin
            edge_count[in_wheel] <= edge_count[in_wheel] - E'(1);
          end
        end
        tpsc_pkg::OP_SPEED_MUL: begin
          mag <= mprod[N-1:0];
          neg <= cnt[E-1];
          edge_count[w] <= '0;
          if (previous_target[w] != tgt[w]) integral_sum[w] <= '0;
          previous_target[w] <= tgt[w];
        end
        tpsc_pkg::OP_SPEED_FIN: speed <= w ? neg_spd[31:0] : sat_spd[31:0];
        tpsc_pkg::OP_FILT_MUL:  fprod <= filtered_speed[w] * $signed({1'b0, tpsc_pkg::KEEP_Q});
        tpsc_pkg::OP_FILT_ADD: begin
          if (f_sum > 37'(S32_MAX))      filtered_speed[w] <= 32'sh7fffffff;
          else if (f_sum < 37'(S32_MIN)) filtered_speed[w] <= 32'sh80000000;
          else                           filtered_speed[w] <= f_sum[31:0];
        end
        tpsc_pkg::OP_ERR: begin
          if (e_diff > 33'(S32_MAX))      err <= 32'sh7fffffff;
          else if (e_diff < 33'(S32_MIN)) err <= 32'sh80000000;
          else                            err <= e_diff[31:0];
        end
        tpsc_pkg::OP_I_MUL: iprod <= 57'($signed({1'b0, ki_sel}) * err);
        tpsc_pkg::OP_I_ADD: begin
          if (control_enable) integral_sum[w] <= i_new[31:0];
        end
        tpsc_pkg::OP_P_MUL: pprod <= 57'($signed({1'b0, kp_sel}) * err);
        tpsc_pkg::OP_DRIVE: begin
          if (w) drive_right <= d_sat;
          else   drive_left  <= d_sat;
        end
        tpsc_pkg::OP_EMIT: begin
          // output register holds the pair until taken
          if (control_enable) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {drive_left, drive_right};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ src/two_wheel_pi_speed_control_top.sv @@
// Top level of the two-wheel PI speed controller with encoder counting.
// Depends on tpsc_pkg, tpsc_ctrl, tpsc_dp (which holds tpsc_div).
//
//  channel  direction  signals                       moves
//  s_*      in         s_tvalid/s_tready/tdata/tuser one edge event or control tick
//  m_*      out        m_tvalid/m_tready/m_tdata     one pair of drive commands
//  cfg_*    in         cfg_we/cfg_index/cfg_data     one register write, no wait
//
// An edge event updates the wheel's count and returns to idle. A control tick runs both wheels through a
// sequence of multiply steps and a restoring divider giving one bit a cycle.
// Reset (rst, synchronous) loads the register defaults and clears all wheel
// state. A stalled result sits in the output register; edge events keep
// transferring meanwhile, and a tick waits only at its end for the register.
module two_wheel_pi_speed_control_top #(
  parameter int EDGE_COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // chan_a, chan_b, target_right[31:0], target_left[31:0], zeros
  input  logic [1:0]  s_tuser,   // mode, wheel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // drive_right[15:0], drive_left[15:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  tpsc_pkg::cmd_t  cmd;
  tpsc_pkg::stat_t stat;

  // sequencer: owns input handshake and step order
  tpsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .in_mode  (s_tuser[0]),
    .stat     (stat),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  // arithmetic, wheel state, config and the output register
  tpsc_dp #(.EDGE_COUNT_BITS(EDGE_COUNT_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // result appears only after an emit step
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.op == tpsc_pkg::OP_EMIT))
    else $error("result without emit step");

  // no input transfer while a tick is in progress
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (cmd.op == tpsc_pkg::OP_NONE))
    else $error("load outside idle");

  // emit never overwrites an untaken result
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == tpsc_pkg::OP_EMIT) |-> (!m_tvalid || m_tready))
    else $error("result overrun");

endmodule
